@@ rtl/h264rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Shared constants and types for the H.264 RTP payload depacketizer.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

   localparam int MAX_PAYLOAD_BYTES = 4096;
   localparam int MAX_UNIT_RECORDS  = 10;

   localparam int POS_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam int RCNT_W = $clog2(MAX_UNIT_RECORDS + 1);
   localparam int NUM_SLOTS = 3;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_RECORD  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // packetization modes
   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_STAPA  = 2'd1;
   localparam logic [1:0] MODE_FUA    = 2'd2;

   // aggregation phases
   localparam logic [1:0] PH_LEN_HI = 2'd0;
   localparam logic [1:0] PH_LEN_LO = 2'd1;
   localparam logic [1:0] PH_FIRST  = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_FU_SHORT  = 3'd2;
   localparam logic [2:0] ST_HDR_SHORT = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;
   localparam logic [2:0] ST_ZERO_UNIT = 3'd5;
   localparam logic [2:0] ST_NESTED    = 3'd6;
   localparam logic [2:0] ST_TOO_LONG  = 3'd7;

   // NAL unit types
   localparam logic [4:0] T_IDR   = 5'd5;
   localparam logic [4:0] T_SPS   = 5'd7;
   localparam logic [4:0] T_PPS   = 5'd8;
   localparam logic [4:0] T_STAPA = 5'd24;
   localparam logic [4:0] T_FUA   = 5'd28;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [4:0]  unit_type;
      logic [11:0] unit_offset;
      logic [15:0] unit_length;
      logic [1:0]  packetization;
      logic        key_frame;
      logic        first_in_frame;
      logic [2:0]  unit_flags;
      logic [2:0]  status;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      result_type [NUM_SLOTS-1:0] items;
      logic [1:0]                 count;
   } result_list_type;

endpackage

@@ rtl/h264rtp_parse.sv @@
// ----------------------------------------------------------------------------
// h264rtp_parse
// Per-packet state and classification; turns one accepted payload byte into
// an ordered list of up to three results.
// ----------------------------------------------------------------------------
module h264rtp_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   payload_byte,
   input  logic                         last_byte,
   input  logic                         empty_payload,
   output h264rtp_pkg::result_list_type results
);

   logic [h264rtp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]                     mode_ff, mode_in;
   logic [7:0]                     ind_ff, ind_in;
   logic [7:0]                     lenhi_ff, lenhi_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [h264rtp_pkg::POS_W-1:0]  ustart_ff, ustart_in;
   logic [15:0]                    urem_ff, urem_in;
   logic [4:0]                     utype_ff, utype_in;
   logic [h264rtp_pkg::RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic [2:0]                     status_ff, status_in;
   logic [3:0]                     flags_ff, flags_in;
   logic [4:0]                     ptype_ff, ptype_in;

   h264rtp_pkg::result_type byte_res, rec_res, sum_res;
   h264rtp_pkg::result_type [h264rtp_pkg::NUM_SLOTS-1:0] cand;
   logic [h264rtp_pkg::NUM_SLOTS-1:0] cand_v;
   logic byte_v, rec_v, sum_v;
   logic [4:0]  t;
   logic [15:0] len_full;
   logic [2:0]  st;
   logic [1:0]  k;

   always_comb begin
      pos_in    = pos_ff;
      mode_in   = mode_ff;
      ind_in    = ind_ff;
      lenhi_in  = lenhi_ff;
      phase_in  = phase_ff;
      ustart_in = ustart_ff;
      urem_in   = urem_ff;
      utype_in  = utype_ff;
      rcnt_in   = rcnt_ff;
      status_in = status_ff;
      flags_in  = flags_ff;
      ptype_in  = ptype_ff;
      byte_res  = '0;
      rec_res   = '0;
      sum_res   = '0;
      byte_v    = 1'b0;
      rec_v     = 1'b0;
      sum_v     = 1'b0;
      t         = payload_byte[4:0];
      len_full  = {lenhi_ff, payload_byte};
      st        = h264rtp_pkg::ST_OK;
      byte_res.kind      = h264rtp_pkg::KIND_BYTE;
      byte_res.data_byte = payload_byte;
      rec_res.kind       = h264rtp_pkg::KIND_RECORD;
      sum_res.kind       = h264rtp_pkg::KIND_SUMMARY;

      if (empty_payload) begin
         sum_v          = 1'b1;
         sum_res.status = h264rtp_pkg::ST_EMPTY;
      end else begin
         if (pos_ff >= h264rtp_pkg::POS_W'(h264rtp_pkg::MAX_PAYLOAD_BYTES)) begin
            status_in = h264rtp_pkg::ST_TOO_LONG;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == '0) begin
               if (t == h264rtp_pkg::T_FUA) begin
                  mode_in = h264rtp_pkg::MODE_FUA;
                  ind_in  = payload_byte;
               end else if (t == h264rtp_pkg::T_STAPA) begin
                  mode_in  = h264rtp_pkg::MODE_STAPA;
                  phase_in = h264rtp_pkg::PH_LEN_HI;
                  byte_v   = 1'b1;
               end else begin
                  mode_in  = h264rtp_pkg::MODE_SINGLE;
                  ptype_in = t;
                  if (t == h264rtp_pkg::T_SPS) flags_in[0] = 1'b1;
                  else if (t == h264rtp_pkg::T_PPS) flags_in[1] = 1'b1;
                  else if (t == h264rtp_pkg::T_IDR) flags_in[2] = 1'b1;
                  byte_v = 1'b1;
               end
            end else if (mode_ff == h264rtp_pkg::MODE_FUA) begin
               if (pos_ff == h264rtp_pkg::POS_W'(1)) begin
                  ptype_in = t;
                  if (t == h264rtp_pkg::T_IDR) flags_in[2] = 1'b1;
                  if (payload_byte[7]) begin
                     flags_in[3]        = 1'b1;
                     byte_v             = 1'b1;
                     byte_res.data_byte = {ind_ff[7:5], t};
                  end
               end else begin
                  byte_v = 1'b1;
               end
            end else if (mode_ff == h264rtp_pkg::MODE_STAPA) begin
               byte_v = 1'b1;
               if (pos_ff == h264rtp_pkg::POS_W'(3)) ptype_in = t;
               case (phase_ff)
                  h264rtp_pkg::PH_LEN_HI: begin
                     lenhi_in = payload_byte;
                     phase_in = h264rtp_pkg::PH_LEN_LO;
                  end
                  h264rtp_pkg::PH_LEN_LO: begin
                     urem_in   = len_full;
                     ustart_in = pos_ff + 1'b1;
                     if (len_full == '0) begin
                        if (status_ff == h264rtp_pkg::ST_OK)
                           status_in = h264rtp_pkg::ST_ZERO_UNIT;
                        phase_in = h264rtp_pkg::PH_LEN_HI;
                     end else begin
                        phase_in = h264rtp_pkg::PH_FIRST;
                     end
                  end
                  h264rtp_pkg::PH_FIRST: begin
                     utype_in = t;
                     if (status_ff == h264rtp_pkg::ST_OK) begin
                        if (t == h264rtp_pkg::T_STAPA || t == h264rtp_pkg::T_FUA) begin
                           status_in = h264rtp_pkg::ST_NESTED;
                        end else begin
                           if (t == h264rtp_pkg::T_SPS) flags_in[0] = 1'b1;
                           else if (t == h264rtp_pkg::T_PPS) flags_in[1] = 1'b1;
                           else if (t == h264rtp_pkg::T_IDR) flags_in[2] = 1'b1;
                           if (rcnt_ff <
                               h264rtp_pkg::RCNT_W'(h264rtp_pkg::MAX_UNIT_RECORDS)) begin
                              rec_v               = 1'b1;
                              rec_res.unit_type   = t;
                              rec_res.unit_offset = ustart_ff[11:0];
                              rec_res.unit_length = urem_ff;
                              rcnt_in             = rcnt_ff + 1'b1;
                           end
                        end
                     end
                     urem_in  = urem_ff - 1'b1;
                     phase_in = (urem_in != '0) ? h264rtp_pkg::PH_DATA
                                                : h264rtp_pkg::PH_LEN_HI;
                  end
                  default: begin
                     urem_in = urem_ff - 1'b1;
                     if (urem_in == '0) phase_in = h264rtp_pkg::PH_LEN_HI;
                  end
               endcase
            end else begin
               byte_v = 1'b1;
            end
         end

         if (last_byte) begin
            st = status_in;
            if (st != h264rtp_pkg::ST_TOO_LONG) begin
               if (mode_in == h264rtp_pkg::MODE_FUA) begin
                  if (pos_in < h264rtp_pkg::POS_W'(2)) st = h264rtp_pkg::ST_FU_SHORT;
               end else if (mode_in == h264rtp_pkg::MODE_STAPA) begin
                  if (pos_in <= h264rtp_pkg::POS_W'(3)) st = h264rtp_pkg::ST_HDR_SHORT;
                  else if (phase_in != h264rtp_pkg::PH_LEN_HI) st = h264rtp_pkg::ST_BAD_LEN;
               end else if (st == h264rtp_pkg::ST_OK) begin
                  rec_v               = 1'b1;
                  rec_res.unit_type   = ptype_in;
                  rec_res.unit_offset = '0;
                  rec_res.unit_length = 16'(pos_in);
               end
            end
            sum_v                 = 1'b1;
            sum_res.unit_type     = ptype_in;
            sum_res.unit_length   = 16'(pos_in);
            sum_res.packetization = mode_in;
            sum_res.status        = st;
            if (st == h264rtp_pkg::ST_OK) begin
               sum_res.key_frame      = flags_in[0] | flags_in[2];
               sum_res.first_in_frame = (mode_in == h264rtp_pkg::MODE_FUA) ? flags_in[3]
                                                                          : 1'b1;
               sum_res.unit_flags     = flags_in[2:0];
            end
         end
      end

      // a finished or abandoned packet starts over
      if (empty_payload || last_byte) begin
         pos_in    = '0;
         mode_in   = h264rtp_pkg::MODE_SINGLE;
         ind_in    = '0;
         lenhi_in  = '0;
         phase_in  = h264rtp_pkg::PH_LEN_HI;
         ustart_in = '0;
         urem_in   = '0;
         utype_in  = '0;
         rcnt_in   = '0;
         status_in = h264rtp_pkg::ST_OK;
         flags_in  = '0;
         ptype_in  = '0;
      end
   end

   // pack the results in order: byte, record, summary
   always_comb begin
      cand    = {sum_res, rec_res, byte_res};
      cand_v  = {sum_v, rec_v, byte_v};
      results = '0;
      k       = '0;
      for (int i = 0; i < h264rtp_pkg::NUM_SLOTS; i++) begin
         if (cand_v[i]) begin
            results.items[k] = cand[i];
            k = k + 1'b1;
         end
      end
      results.count = k;
      if (k != '0) results.items[k - 1'b1].last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         mode_ff   <= h264rtp_pkg::MODE_SINGLE;
         ind_ff    <= '0;
         lenhi_ff  <= '0;
         phase_ff  <= h264rtp_pkg::PH_LEN_HI;
         ustart_ff <= '0;
         urem_ff   <= '0;
         utype_ff  <= '0;
         rcnt_ff   <= '0;
         status_ff <= h264rtp_pkg::ST_OK;
         flags_ff  <= '0;
         ptype_ff  <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         mode_ff   <= mode_in;
         ind_ff    <= ind_in;
         lenhi_ff  <= lenhi_in;
         phase_ff  <= phase_in;
         ustart_ff <= ustart_in;
         urem_ff   <= urem_in;
         utype_ff  <= utype_in;
         rcnt_ff   <= rcnt_in;
         status_ff <= status_in;
         flags_ff  <= flags_in;
         ptype_ff  <= ptype_in;
      end
   end

endmodule

@@ rtl/h264rtp_outbuf.sv @@
// ----------------------------------------------------------------------------
// h264rtp_outbuf
// Result register: holds the up to three results of one transaction and
// hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module h264rtp_outbuf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  h264rtp_pkg::result_list_type results,
   output logic                         load_ready,
   output logic                         out_valid,
   input  logic                         out_ready,
   output h264rtp_pkg::result_type      out_item
);

   h264rtp_pkg::result_type [h264rtp_pkg::NUM_SLOTS-1:0] slot_ff, slot_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid  = (cnt_ff != '0);
   assign out_item   = slot_ff[0];
   assign pop        = out_valid & out_ready;
   // room only when the buffer drains this cycle
   assign load_ready = (cnt_ff == '0) || (cnt_ff == 2'd1 && out_ready);

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = results.items;
         cnt_in  = results.count;
      end else if (pop) begin
         slot_in = {slot_ff[h264rtp_pkg::NUM_SLOTS-1],
                    slot_ff[h264rtp_pkg::NUM_SLOTS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/h264_rtp_payload_depacketizer_unit.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_payload_depacketizer_unit
// H.264 RTP payload depacketizer (single NAL unit, STAP-A, FU-A).
// ----------------------------------------------------------------------------
// Takes one payload byte per transaction and produces payload bytes, unit
// records and a packet summary on the result stream (tuser gives the kind,
// tlast marks the final result of each input transaction). A byte is taken
// every cycle while the receiver is ready and each byte yields one result at
// most; a byte with two or three results (a record beside a byte, or the
// final byte of a packet) holds the input until all but the last have left
// the result register, handing out one result per cycle. A nonzero status in
// the summary means every byte and record of that packet is to be discarded.
module h264_rtp_payload_depacketizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // empty_payload
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] data_byte, [12:8] unit_type,
                                    // [24:13] unit_offset, [40:25] unit_length,
                                    // [42:41] packetization, [43] key_frame,
                                    // [44] first_in_frame, [47:45] unit_flags,
                                    // [50:48] status, [55:51] zero
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser    // kind
);

   h264rtp_pkg::result_list_type results;
   h264rtp_pkg::result_type      out_item;
   logic                         accept;

   assign accept = req_tvalid & req_tready;

   h264rtp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .payload_byte  (req_tdata),
      .last_byte     (req_tlast),
      .empty_payload (req_tuser),
      .results       (results)
   );

   h264rtp_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .results    (results),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = {5'd0,
                       out_item.status,
                       out_item.unit_flags,
                       out_item.first_in_frame,
                       out_item.key_frame,
                       out_item.packetization,
                       out_item.unit_length,
                       out_item.unit_offset,
                       out_item.unit_type,
                       out_item.data_byte};
   assign rsp_tlast = out_item.last_of_run;
   assign rsp_tuser = out_item.kind;

endmodule

@@ tb/tb_h264_rtp_payload_depacketizer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_h264_rtp_payload_depacketizer_unit
// Self-checking bench for the H.264 RTP payload depacketizer. Starts with a
// directed table of packets, then sends random single NAL, STAP-A and FU-A
// packets (mostly well formed, some broken) under several sender and
// receiver idle mixes. Each result transaction is checked field by field
// against an in-bench model of the depacketizer or a typed table row.
// ----------------------------------------------------------------------------
module tb_h264_rtp_payload_depacketizer_unit;

   typedef struct packed {
      logic [7:0]              payload;
      logic                    is_last;
      logic                    is_empty;
      logic                    typed;
      h264rtp_pkg::result_type want;
   } directed_row_type;

   localparam h264rtp_pkg::result_type NO_RESULT = '0;
   localparam h264rtp_pkg::result_type EMPTY_SUMMARY = '{h264rtp_pkg::KIND_SUMMARY, 8'd0,
      5'd0, 12'd0, 16'd0, h264rtp_pkg::MODE_SINGLE, 1'b0, 1'b0, 3'd0, h264rtp_pkg::ST_EMPTY,
      1'b1};
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] payload_byte
   logic        req_tlast = 1'b0;   // last_byte
   logic        req_tuser = 1'b0;   // empty_payload
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // [7:0] data_byte, [12:8] unit_type,
                                    // [24:13] unit_offset, [40:25] unit_length,
                                    // [42:41] packetization, [43] key_frame,
                                    // [44] first_in_frame, [47:45] unit_flags,
                                    // [50:48] status, [55:51] zero
   logic        rsp_tlast;          // last_of_run
   logic [1:0]  rsp_tuser;          // kind

   h264_rtp_payload_depacketizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb_h264_rtp_payload_depacketizer_unit: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Depacketizer model
   // ------------------------------------------------------------------------
   logic [12:0] dp_pos;
   logic [1:0]  dp_mode;
   logic [7:0]  dp_fu_indicator;
   logic [7:0]  dp_len_high;
   logic [1:0]  dp_phase;
   logic [12:0] dp_unit_start;
   logic [15:0] dp_unit_left;
   logic [3:0]  dp_records;
   logic [2:0]  dp_status;
   logic [3:0]  dp_flags;          // SPS, PPS, IDR, FU-A start
   logic [4:0]  dp_pkt_type;

   h264rtp_pkg::result_type step_out [3];
   int                      step_n;
   h264rtp_pkg::result_type pending_results [$];

   function automatic void queue_result(input h264rtp_pkg::result_type r);
      pending_results = {pending_results, r};
   endfunction

   function automatic void clear_packet_state();
      dp_pos = '0; dp_mode = h264rtp_pkg::MODE_SINGLE; dp_fu_indicator = '0;
      dp_len_high = '0; dp_phase = h264rtp_pkg::PH_LEN_HI; dp_unit_start = '0;
      dp_unit_left = '0; dp_records = '0; dp_status = h264rtp_pkg::ST_OK; dp_flags = '0;
      dp_pkt_type = '0;
   endfunction

   function automatic void emit_byte(input logic [7:0] value);
      step_out[step_n] = NO_RESULT;
      step_out[step_n].kind = h264rtp_pkg::KIND_BYTE;
      step_out[step_n].data_byte = value;
      step_n++;
   endfunction

   function automatic void emit_record(input logic [4:0] t, input logic [11:0] offset,
                                       input logic [15:0] length);
      step_out[step_n] = NO_RESULT;
      step_out[step_n].kind = h264rtp_pkg::KIND_RECORD;
      step_out[step_n].unit_type = t;
      step_out[step_n].unit_offset = offset;
      step_out[step_n].unit_length = length;
      step_n++;
   endfunction

   function automatic void mark_unit_type(input logic [4:0] t);
      if (t == h264rtp_pkg::T_SPS) dp_flags[0] = 1'b1;
      else if (t == h264rtp_pkg::T_PPS) dp_flags[1] = 1'b1;
      else if (t == h264rtp_pkg::T_IDR) dp_flags[2] = 1'b1;
   endfunction

   function automatic void close_packet();
      logic [2:0] st;
      st = dp_status;
      if (st != h264rtp_pkg::ST_TOO_LONG) begin
         if (dp_mode == h264rtp_pkg::MODE_FUA) begin
            if (dp_pos < 2) st = h264rtp_pkg::ST_FU_SHORT;
         end else if (dp_mode == h264rtp_pkg::MODE_STAPA) begin
            if (dp_pos <= 3) st = h264rtp_pkg::ST_HDR_SHORT;
            else if (dp_phase != h264rtp_pkg::PH_LEN_HI) st = h264rtp_pkg::ST_BAD_LEN;
         end else if (st == h264rtp_pkg::ST_OK) begin
            emit_record(dp_pkt_type, 12'd0, {3'd0, dp_pos});
         end
      end
      step_out[step_n] = NO_RESULT;
      step_out[step_n].kind = h264rtp_pkg::KIND_SUMMARY;
      step_out[step_n].unit_type = dp_pkt_type;
      step_out[step_n].unit_length = {3'd0, dp_pos};
      step_out[step_n].packetization = dp_mode;
      step_out[step_n].status = st;
      if (st == h264rtp_pkg::ST_OK) begin
         step_out[step_n].key_frame = dp_flags[0] | dp_flags[2];
         step_out[step_n].first_in_frame = (dp_mode == h264rtp_pkg::MODE_FUA) ? dp_flags[3]
                                                                             : 1'b1;
         step_out[step_n].unit_flags = dp_flags[2:0];
      end
      step_n++;
      clear_packet_state();
   endfunction

   function automatic void depacketize_byte(input logic [7:0] b, input logic is_last,
                                            input logic is_empty);
      logic [12:0] p;
      logic [4:0]  t;
      step_n = 0;
      if (is_empty) begin
         // abandons whatever packet was open
         clear_packet_state();
         step_out[0] = EMPTY_SUMMARY;
         step_n = 1;
         return;
      end
      p = dp_pos;
      t = b[4:0];
      if (p >= h264rtp_pkg::MAX_PAYLOAD_BYTES) begin
         dp_status = h264rtp_pkg::ST_TOO_LONG;
      end else begin
         dp_pos = p + 13'd1;
         if (p == 0) begin
            if (t == h264rtp_pkg::T_FUA) begin
               dp_mode = h264rtp_pkg::MODE_FUA;
               dp_fu_indicator = b;
            end else if (t == h264rtp_pkg::T_STAPA) begin
               dp_mode = h264rtp_pkg::MODE_STAPA;
               dp_phase = h264rtp_pkg::PH_LEN_HI;
               emit_byte(b);
            end else begin
               dp_mode = h264rtp_pkg::MODE_SINGLE;
               dp_pkt_type = t;
               mark_unit_type(t);
               emit_byte(b);
            end
         end else if (dp_mode == h264rtp_pkg::MODE_FUA) begin
            if (p == 1) begin
               dp_pkt_type = t;
               if (t == h264rtp_pkg::T_IDR) dp_flags[2] = 1'b1;
               if (b[7]) begin
                  dp_flags[3] = 1'b1;
                  emit_byte({dp_fu_indicator[7:5], t});
               end
            end else begin
               emit_byte(b);
            end
         end else if (dp_mode == h264rtp_pkg::MODE_STAPA) begin
            emit_byte(b);
            if (p == 3) dp_pkt_type = t;
            case (dp_phase)
               h264rtp_pkg::PH_LEN_HI: begin
                  dp_len_high = b;
                  dp_phase = h264rtp_pkg::PH_LEN_LO;
               end
               h264rtp_pkg::PH_LEN_LO: begin
                  dp_unit_left = {dp_len_high, b};
                  dp_unit_start = p + 13'd1;
                  if (dp_unit_left == 0) begin
                     if (dp_status == h264rtp_pkg::ST_OK) dp_status = h264rtp_pkg::ST_ZERO_UNIT;
                     dp_phase = h264rtp_pkg::PH_LEN_HI;
                  end else begin
                     dp_phase = h264rtp_pkg::PH_FIRST;
                  end
               end
               h264rtp_pkg::PH_FIRST: begin
                  if (dp_status == h264rtp_pkg::ST_OK) begin
                     if (t == h264rtp_pkg::T_STAPA || t == h264rtp_pkg::T_FUA) begin
                        dp_status = h264rtp_pkg::ST_NESTED;
                     end else begin
                        mark_unit_type(t);
                        if (dp_records < h264rtp_pkg::MAX_UNIT_RECORDS) begin
                           emit_record(t, dp_unit_start[11:0], dp_unit_left);
                           dp_records++;
                        end
                     end
                  end
                  dp_unit_left--;
                  dp_phase = (dp_unit_left != 0) ? h264rtp_pkg::PH_DATA
                                                 : h264rtp_pkg::PH_LEN_HI;
               end
               default: begin
                  dp_unit_left--;
                  if (dp_unit_left == 0) dp_phase = h264rtp_pkg::PH_LEN_HI;
               end
            endcase
         end else begin
            emit_byte(b);
         end
      end
      if (is_last) close_packet();
      if (step_n > 0) step_out[step_n - 1].last_of_run = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver side and result checking
   // ------------------------------------------------------------------------
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          failures = 0;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      h264rtp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d tdata %h", rsp_tuser, rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("data_byte", want.data_byte, rsp_tdata[7:0]);
            check_field("unit_type", want.unit_type, rsp_tdata[12:8]);
            check_field("unit_offset", want.unit_offset, rsp_tdata[24:13]);
            check_field("unit_length", want.unit_length, rsp_tdata[40:25]);
            check_field("packetization", want.packetization, rsp_tdata[42:41]);
            check_field("key_frame", want.key_frame, rsp_tdata[43]);
            check_field("first_in_frame", want.first_in_frame, rsp_tdata[44]);
            check_field("unit_flags", want.unit_flags, rsp_tdata[47:45]);
            check_field("status", want.status, rsp_tdata[50:48]);
            check_field("pad", 0, rsp_tdata[55:51]);
            check_field("last_of_run", want.last_of_run, rsp_tlast);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   int          items_sent = 0;
   logic [7:0]  packet_bytes [$];

   function automatic void add_byte(input logic [7:0] value);
      packet_bytes = {packet_bytes, value};
   endfunction

   // Called at a rising edge; returns at the edge that accepts the transaction.
   task automatic send_item(input logic [7:0] payload, input logic is_last,
                            input logic is_empty, input logic typed,
                            input h264rtp_pkg::result_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= payload;
      req_tlast <= is_last;
      req_tuser <= is_empty;
      do @(posedge clock); while (!req_tready);
      depacketize_byte(payload, is_last, is_empty);
      if (typed) queue_result(want);
      else for (int i = 0; i < step_n; i++) queue_result(step_out[i]);
      items_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++)
         send_item(packet_bytes[i], i == packet_bytes.size() - 1, 1'b0, 1'b0, NO_RESULT);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [2:0] rand_fnri();
      return 3'($urandom_range(7));
   endfunction

   // any type that does not turn a unit into an aggregate or a fragment
   function automatic logic [4:0] pick_unit_type();
      logic [4:0] t;
      case ($urandom_range(4))
         0: t = h264rtp_pkg::T_IDR;
         1: t = h264rtp_pkg::T_SPS;
         2: t = h264rtp_pkg::T_PPS;
         default: begin
            t = 5'($urandom_range(31));
            if (t == h264rtp_pkg::T_STAPA || t == h264rtp_pkg::T_FUA) t = 5'd1;
         end
      endcase
      return t;
   endfunction

   function automatic void build_single(input int extra);
      packet_bytes.delete();
      add_byte({rand_fnri(), pick_unit_type()});
      for (int i = 0; i < extra; i++) add_byte(rand_byte());
   endfunction

   function automatic void build_fu(input int extra);
      logic [7:0] fu_header;
      packet_bytes.delete();
      add_byte({rand_fnri(), h264rtp_pkg::T_FUA});
      if ($urandom_range(3) == 0) fu_header = rand_byte();
      else fu_header = {1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, pick_unit_type()};
      add_byte(fu_header);
      for (int i = 0; i < extra; i++) add_byte(rand_byte());
   endfunction

   function automatic void build_stap(input int units, input int min_len, input int max_len,
                                      input int zero_at, input int nested_at);
      int len;
      packet_bytes.delete();
      add_byte({rand_fnri(), h264rtp_pkg::T_STAPA});
      for (int u = 0; u < units; u++) begin
         len = (u == zero_at) ? 0 : $urandom_range(max_len, min_len);
         add_byte(len[15:8]);
         add_byte(len[7:0]);
         if (len > 0) begin
            if (u == nested_at)
               add_byte({rand_fnri(), ($urandom_range(1) != 0) ? h264rtp_pkg::T_STAPA
                                                               : h264rtp_pkg::T_FUA});
            else
               add_byte({rand_fnri(), pick_unit_type()});
            for (int k = 1; k < len; k++) add_byte(rand_byte());
         end
      end
   endfunction

   task automatic send_random_packet();
      int sel;
      int units;
      int cut;
      sel = $urandom_range(99);
      units = ($urandom_range(3) == 0) ? $urandom_range(13, 9) : $urandom_range(4, 1);
      if (sel < 24) begin
         build_single($urandom_range(10));
      end else if (sel < 48) begin
         build_stap(units, 1, (units > 8) ? 2 : 5, -1, -1);
      end else if (sel < 70) begin
         build_fu($urandom_range(8));
      end else if (sel < 74) begin
         packet_bytes.delete();
         add_byte({rand_fnri(), h264rtp_pkg::T_FUA});
      end else if (sel < 78) begin
         // aggregate that ends inside its own header
         packet_bytes.delete();
         add_byte({rand_fnri(), h264rtp_pkg::T_STAPA});
         cut = $urandom_range(2);
         for (int i = 0; i < cut; i++) add_byte(rand_byte());
      end else if (sel < 83) begin
         // aggregate cut off inside a length field or a unit
         build_stap($urandom_range(3, 1), 1, 6, -1, -1);
         cut = $urandom_range(packet_bytes.size() - 1, 4);
         while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
      end else if (sel < 87) begin
         units = $urandom_range(4, 1);
         build_stap(units, 1, 4, $urandom_range(units - 1), $urandom_range(units));
      end else if (sel < 91) begin
         units = $urandom_range(4, 1);
         build_stap(units, 1, 4, -1, $urandom_range(units - 1));
      end else if (sel < 95) begin
         send_item(rand_byte(), 1'($urandom_range(1)), 1'b1, 1'b0, NO_RESULT);
         return;
      end else begin
         packet_bytes.delete();
         cut = $urandom_range(8, 1);
         for (int i = 0; i < cut; i++) add_byte(rand_byte());
      end
      send_packet();
   endtask

   directed_row_type directed_rows [0:22] = '{
      '{8'hFF, 1'b1, 1'b1, 1'b1, EMPTY_SUMMARY},
      // FU-A with its indicator only
      '{8'h7C, 1'b1, 1'b0, 1'b1, '{h264rtp_pkg::KIND_SUMMARY, 8'd0, 5'd0, 12'd0, 16'd1,
         h264rtp_pkg::MODE_FUA, 1'b0, 1'b0, 3'd0, h264rtp_pkg::ST_FU_SHORT, 1'b1}},
      '{8'h65, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // FU-A start fragment of an IDR
      '{8'h7C, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h85, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // STAP-A carrying an SPS and a PPS
      '{8'h18, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h67, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h42, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h68, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // STAP-A holding an FU-A unit
      '{8'h18, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h7C, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // empty payload drops the open FU-A
      '{8'h5C, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_SUMMARY}
   };

   initial begin
      int phase_start;
      clear_packet_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].payload, directed_rows[i].is_last,
                   directed_rows[i].is_empty, directed_rows[i].typed, directed_rows[i].want);
      req_tvalid <= 1'b0;
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         // receiver holds off while packets keep coming
         if (ph == 0) hold_requests <= hold_requests + 1;
         phase_start = items_sent;
         while (items_sent - phase_start < 22) send_random_packet();
         req_tvalid <= 1'b0;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("tb_h264_rtp_payload_depacketizer_unit: PASS");
      end else begin
         $display("tb_h264_rtp_payload_depacketizer_unit: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/h264rtp_pkg.sv
rtl/h264rtp_parse.sv
rtl/h264rtp_outbuf.sv
rtl/h264_rtp_payload_depacketizer_unit.sv
tb/tb_h264_rtp_payload_depacketizer_unit.sv
